### design/hpm_pkg.sv
// Shared types, widths and constants for the homography point mapper.
// No dependencies; every other design file imports this package.
package hpm_pkg;

    localparam int PIXEL_WIDTH = 16;

    localparam int COEF_W    = 48;
    localparam int COEF_HALF = COEF_W / 2;
    localparam int COEF_FRAC = 32;
    localparam int IN_W      = 32;
    localparam int IN_FRAC   = 16;
    localparam int NUM_COEFS = 8;
    localparam int CFG_IDX_W = $clog2(NUM_COEFS);

    // Partial product of a 24-bit coefficient half and a 32-bit coordinate.
    localparam int PP_W  = IN_W + COEF_HALF + 1;
    // Exact Q.48 sums of the matrix rows.
    localparam int ACC_W = 82;
    // Rounded-division numerator 2|n| + |d| and divisor 2|d|.
    localparam int MAG_W = ACC_W + 2;
    // Quotient bits kept; anything wider saturates anyway.
    localparam int QBITS = PIXEL_WIDTH + 1;
    localparam int SH_W  = MAG_W + QBITS;

    localparam int ROW_STAGES  = 3;
    localparam int PREP_STAGES = 3;
    localparam int LATENCY     = ROW_STAGES + PREP_STAGES + QBITS + 1;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] IDX_COEF_XX = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] IDX_COEF_XY = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] IDX_COEF_XT = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] IDX_COEF_YX = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] IDX_COEF_YY = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] IDX_COEF_YT = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] IDX_PERSP_X = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] IDX_PERSP_Y = CFG_IDX_W'(7);

    localparam logic signed [COEF_W-1:0] COEF_ONE  = COEF_W'(1) << COEF_FRAC;
    localparam logic signed [COEF_W-1:0] COEF_ZERO = '0;
    localparam logic signed [ACC_W-1:0]  W_ONE     = ACC_W'(1) << (COEF_FRAC + IN_FRAC);

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DEN_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT      = 2'd2;

    localparam logic signed [PIXEL_WIDTH-1:0] PIX_MAX = {1'b0, {(PIXEL_WIDTH-1){1'b1}}};
    localparam logic signed [PIXEL_WIDTH-1:0] PIX_MIN = {1'b1, {(PIXEL_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic signed [IN_W-1:0] world_x;
        logic signed [IN_W-1:0] world_y;
    } point_t;

    typedef struct packed {
        logic signed [PIXEL_WIDTH-1:0] pixel_x;
        logic signed [PIXEL_WIDTH-1:0] pixel_y;
        logic [1:0]                    status;
    } pixel_t;

    // State of both divisions as it moves down the divider stages.
    typedef struct packed {
        logic [SH_W-1:0]  rem_u;
        logic [SH_W-1:0]  rem_v;
        logic [SH_W-1:0]  dsh;
        logic [QBITS-1:0] q_u;
        logic [QBITS-1:0] q_v;
        logic             big_u;
        logic             big_v;
        logic             neg_u;
        logic             neg_v;
        logic             zero;
    } div_t;

endpackage

### design/hpm_row.sv
// One matrix row: c_a*x + c_b*y + addend, exact, over three register stages.
// Depends on hpm_pkg.
module hpm_row (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [hpm_pkg::IN_W-1:0]    x,
    input  logic signed [hpm_pkg::IN_W-1:0]    y,
    input  logic signed [hpm_pkg::COEF_W-1:0]  ca,
    input  logic signed [hpm_pkg::COEF_W-1:0]  cb,
    input  logic signed [hpm_pkg::ACC_W-1:0]   addend,
    output logic signed [hpm_pkg::ACC_W-1:0]   sum
);
    import hpm_pkg::*;

    logic signed [PP_W-1:0]  lo_a_reg, lo_a_next, hi_a_reg, hi_a_next;
    logic signed [PP_W-1:0]  lo_b_reg, lo_b_next, hi_b_reg, hi_b_next;
    logic signed [ACC_W-1:0] prod_a_reg, prod_a_next, prod_b_reg, prod_b_next;
    logic signed [ACC_W-1:0] sum_reg, sum_next;

    // Each 48-bit coefficient is split into a signed upper half and an
    // unsigned lower half so that no multiplier exceeds 25 by 32 bits.
    always_comb
    begin
        lo_a_next   = $signed({1'b0, ca[COEF_HALF-1:0]}) * x;
        hi_a_next   = $signed(ca[COEF_W-1:COEF_HALF]) * x;
        lo_b_next   = $signed({1'b0, cb[COEF_HALF-1:0]}) * y;
        hi_b_next   = $signed(cb[COEF_W-1:COEF_HALF]) * y;
        prod_a_next = (ACC_W'(hi_a_reg) <<< COEF_HALF) + ACC_W'(lo_a_reg);
        prod_b_next = (ACC_W'(hi_b_reg) <<< COEF_HALF) + ACC_W'(lo_b_reg);
        sum_next    = prod_a_reg + prod_b_reg + addend;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_a_reg   <= lo_a_next;
            hi_a_reg   <= hi_a_next;
            lo_b_reg   <= lo_b_next;
            hi_b_reg   <= hi_b_next;
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
            sum_reg    <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

### design/hpm_prep.sv
// Sign and magnitude split, rounding offset and overflow check ahead of the
// divider, over three register stages. Depends on hpm_pkg.
module hpm_prep (
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [hpm_pkg::ACC_W-1:0] u,
    input  logic signed [hpm_pkg::ACC_W-1:0] v,
    input  logic signed [hpm_pkg::ACC_W-1:0] w,
    output hpm_pkg::div_t                    d_out
);
    import hpm_pkg::*;

    logic [ACC_W-1:0] mag_u_reg, mag_u_next, mag_v_reg, mag_v_next, mag_w_reg, mag_w_next;
    logic             neg_u_reg, neg_u_next, neg_v_reg, neg_v_next, zero_reg, zero_next;
    logic [MAG_W-1:0] top_u_reg, top_u_next, top_v_reg, top_v_next, bot_reg, bot_next;
    logic             neg_u2_reg, neg_v2_reg, zero2_reg;
    logic [SH_W-1:0]  dsh;
    div_t             div_reg, div_next;

    always_comb
    begin
        mag_u_next = u[ACC_W-1] ? ACC_W'(-u) : ACC_W'(u);
        mag_v_next = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        mag_w_next = w[ACC_W-1] ? ACC_W'(-w) : ACC_W'(w);
        neg_u_next = u[ACC_W-1] ^ w[ACC_W-1];
        neg_v_next = v[ACC_W-1] ^ w[ACC_W-1];
        zero_next  = (w == '0);

        // Rounding half away from zero: floor((2|n| + |d|) / (2|d|)).
        top_u_next = MAG_W'({mag_u_reg, 1'b0}) + MAG_W'(mag_w_reg);
        top_v_next = MAG_W'({mag_v_reg, 1'b0}) + MAG_W'(mag_w_reg);
        bot_next   = MAG_W'({mag_w_reg, 1'b0});

        // A quotient that needs more than QBITS bits saturates for sure.
        dsh            = SH_W'(bot_reg) << QBITS;
        div_next.rem_u = SH_W'(top_u_reg);
        div_next.rem_v = SH_W'(top_v_reg);
        div_next.dsh   = dsh;
        div_next.q_u   = '0;
        div_next.q_v   = '0;
        div_next.big_u = (SH_W'(top_u_reg) >= dsh);
        div_next.big_v = (SH_W'(top_v_reg) >= dsh);
        div_next.neg_u = neg_u2_reg;
        div_next.neg_v = neg_v2_reg;
        div_next.zero  = zero2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_u_reg  <= mag_u_next;
            mag_v_reg  <= mag_v_next;
            mag_w_reg  <= mag_w_next;
            neg_u_reg  <= neg_u_next;
            neg_v_reg  <= neg_v_next;
            zero_reg   <= zero_next;
            top_u_reg  <= top_u_next;
            top_v_reg  <= top_v_next;
            bot_reg    <= bot_next;
            neg_u2_reg <= neg_u_reg;
            neg_v2_reg <= neg_v_reg;
            zero2_reg  <= zero_reg;
            div_reg    <= div_next;
        end
    end

    assign d_out = div_reg;

endmodule

### design/hpm_div_step.sv
// One restoring-division step for both quotients, one quotient bit each.
// Depends on hpm_pkg.
module hpm_div_step (
    input  logic          clk,
    input  logic          en,
    input  hpm_pkg::div_t d_in,
    output hpm_pkg::div_t d_out
);
    import hpm_pkg::*;

    logic [SH_W-1:0] dn;
    div_t            div_reg, div_next;

    always_comb
    begin
        dn           = d_in.dsh >> 1;
        div_next     = d_in;
        div_next.dsh = dn;
        if (d_in.rem_u >= dn)
        begin
            div_next.rem_u = d_in.rem_u - dn;
            div_next.q_u   = {d_in.q_u[QBITS-2:0], 1'b1};
        end
        else
        begin
            div_next.q_u = {d_in.q_u[QBITS-2:0], 1'b0};
        end
        if (d_in.rem_v >= dn)
        begin
            div_next.rem_v = d_in.rem_v - dn;
            div_next.q_v   = {d_in.q_v[QBITS-2:0], 1'b1};
        end
        else
        begin
            div_next.q_v = {d_in.q_v[QBITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg <= div_next;
        end
    end

    assign d_out = div_reg;

endmodule

### design/hpm_round.sv
// Saturation, sign restore and status of the finished quotients; this is
// the output register of the block. Depends on hpm_pkg.
module hpm_round (
    input  logic           clk,
    input  logic           en,
    input  hpm_pkg::div_t  d_in,
    output hpm_pkg::pixel_t px_out
);
    import hpm_pkg::*;

    localparam logic [QBITS-1:0] HALF = QBITS'(1) << (PIXEL_WIDTH - 1);

    logic [PIXEL_WIDTH:0] res_u, res_v;
    pixel_t               px_reg, px_next;

    // Returns {saturated, value}.
    function automatic logic [PIXEL_WIDTH:0] clamp(input logic [QBITS-1:0] q,
                                                   input logic big, input logic neg);
        logic             sat;
        logic [QBITS-1:0] mag;
        logic [QBITS-1:0] val;
        sat = big || (neg ? (q > HALF) : (q >= HALF));
        mag = sat ? (neg ? HALF : HALF - QBITS'(1)) : q;
        val = neg ? QBITS'(-mag) : mag;
        return {sat, val[PIXEL_WIDTH-1:0]};
    endfunction

    always_comb
    begin
        res_u = clamp(d_in.q_u, d_in.big_u, d_in.neg_u);
        res_v = clamp(d_in.q_v, d_in.big_v, d_in.neg_v);
        if (d_in.zero)
        begin
            px_next.pixel_x = '0;
            px_next.pixel_y = '0;
            px_next.status  = ST_DEN_ZERO;
        end
        else
        begin
            px_next.pixel_x = $signed(res_u[PIXEL_WIDTH-1:0]);
            px_next.pixel_y = $signed(res_v[PIXEL_WIDTH-1:0]);
            px_next.status  = (res_u[PIXEL_WIDTH] || res_v[PIXEL_WIDTH]) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= px_next;
        end
    end

    assign px_out = px_reg;

endmodule

### design/homography_point_mapper.sv
// Homography point mapper: maps world points through a projective 3x3 matrix.
// Depends on hpm_pkg, hpm_row, hpm_prep, hpm_div_step and hpm_round.
//
// Usage:
//   The pt channel carries one world point (Q16.16 x and y) per transfer; the
//   px channel returns one result per point: rounded, saturated pixel x and y
//   and a status (ok, zero denominator, saturated). Both channels use valid
//   and stall; a transfer happens on a clock edge with valid high and stall
//   low. The eight Q16.32 matrix coefficients are written through cfg_we,
//   cfg_index and cfg_data; the user must write them only while no point
//   is in flight (the block does not enforce this). A point passes through
//   three stages of row multiply-accumulate, three of sign split and
//   rounding setup, one divider stage per quotient bit (17 for 16-bit
//   pixels), and the output register. Throughput is one point per clock
//   unless px stalls; with no loop, a new point may follow in every cycle.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   pt_stall goes high in the same cycle; nothing is dropped or repeated.
//   Reset empties the pipeline and loads the identity matrix.
module homography_point_mapper (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pt_valid,
    output logic                                pt_stall,
    input  hpm_pkg::point_t                     pt,
    output logic                                px_valid,
    input  logic                                px_stall,
    output hpm_pkg::pixel_t                     px,
    input  logic                                cfg_we,
    input  logic [hpm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hpm_pkg::COEF_W-1:0]          cfg_data
);
    import hpm_pkg::*;

    logic signed [COEF_W-1:0] coef_reg [NUM_COEFS];
    logic [LATENCY-1:0]       valid_reg, valid_next;
    logic                     en;
    logic signed [ACC_W-1:0]  u_sum, v_sum, w_sum;
    logic signed [ACC_W-1:0]  u_add, v_add;
    div_t                     div_bus [QBITS+1];

    // The pipeline advances unless a finished result is held by the receiver.
    assign en       = !(valid_reg[LATENCY-1] && px_stall);
    assign pt_stall = !en;
    assign px_valid = valid_reg[LATENCY-1];

    assign valid_next = {valid_reg[LATENCY-2:0], pt_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    // Coefficient registers; reset gives the identity mapping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEFS; i++)
            begin
                coef_reg[i] <= COEF_ZERO;
            end
            coef_reg[IDX_COEF_XX] <= COEF_ONE;
            coef_reg[IDX_COEF_YY] <= COEF_ONE;
        end
        else if (cfg_we)
        begin
            coef_reg[cfg_index] <= $signed(cfg_data);
        end
    end

    // The translation terms multiply the constant 1.0 in Q16.16.
    assign u_add = ACC_W'(coef_reg[IDX_COEF_XT]) <<< IN_FRAC;
    assign v_add = ACC_W'(coef_reg[IDX_COEF_YT]) <<< IN_FRAC;

    hpm_row u_row_u (
        .clk    (clk),
        .en     (en),
        .x      (pt.world_x),
        .y      (pt.world_y),
        .ca     (coef_reg[IDX_COEF_XX]),
        .cb     (coef_reg[IDX_COEF_XY]),
        .addend (u_add),
        .sum    (u_sum)
    );

    hpm_row u_row_v (
        .clk    (clk),
        .en     (en),
        .x      (pt.world_x),
        .y      (pt.world_y),
        .ca     (coef_reg[IDX_COEF_YX]),
        .cb     (coef_reg[IDX_COEF_YY]),
        .addend (v_add),
        .sum    (v_sum)
    );

    hpm_row u_row_w (
        .clk    (clk),
        .en     (en),
        .x      (pt.world_x),
        .y      (pt.world_y),
        .ca     (coef_reg[IDX_PERSP_X]),
        .cb     (coef_reg[IDX_PERSP_Y]),
        .addend (W_ONE),
        .sum    (w_sum)
    );

    hpm_prep u_prep (
        .clk   (clk),
        .en    (en),
        .u     (u_sum),
        .v     (v_sum),
        .w     (w_sum),
        .d_out (div_bus[0])
    );

    // One divider stage per quotient bit, most significant bit first.
    for (genvar g = 0; g < QBITS; g++)
    begin : g_div
        hpm_div_step u_step (
            .clk   (clk),
            .en    (en),
            .d_in  (div_bus[g]),
            .d_out (div_bus[g+1])
        );
    end

    hpm_round u_round (
        .clk    (clk),
        .en     (en),
        .d_in   (div_bus[QBITS]),
        .px_out (px)
    );

    // A zero denominator always reports the origin.
    a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
        (px_valid && px.status == ST_DEN_ZERO) |-> (px.pixel_x == '0 && px.pixel_y == '0))
        else $error("zero denominator result is not the origin");

    // A saturated result has at least one coordinate at a range bound.
    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (px_valid && px.status == ST_SAT) |->
        (px.pixel_x == PIX_MAX || px.pixel_x == PIX_MIN ||
         px.pixel_y == PIX_MAX || px.pixel_y == PIX_MIN))
        else $error("saturated result is not clamped");

    // Status never carries the unused code.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        px_valid |-> (px.status == ST_OK || px.status == ST_DEN_ZERO || px.status == ST_SAT))
        else $error("invalid status code");

endmodule
